// File: hw/rtl/bmf_pkg.sv
package bmf_pkg;

  // Width of the per-frame item counter.
  localparam int CNT_W = 21;

  // Foreground threshold, 0.5 in signed Q8.8.
  localparam logic signed [15:0] FG_LEVEL = 16'sd128;

  // Configuration register indexes.
  localparam logic [7:0] REG_MODE   = 8'd0;
  localparam logic [7:0] REG_RADIUS = 8'd1;
  localparam logic [7:0] REG_WIDTH  = 8'd2;
  localparam logic [7:0] REG_HEIGHT = 8'd3;

  typedef enum logic [2:0] {
    MODE_ERODE    = 3'd0,
    MODE_DILATE   = 3'd1,
    MODE_OPEN     = 3'd2,
    MODE_CLOSE    = 3'd3,
    MODE_GRADIENT = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PASS1,
    ST_WAIT1,
    ST_PASS2,
    ST_WAIT2,
    ST_FINISH
  } state_t;

  // Window scan request: start pulse and which store to scan.
  typedef struct packed {
    logic start;
    logic second;
  } win_req_t;

  // Window scan result: done pulse, OR and AND over the window.
  typedef struct packed {
    logic done;
    logic any_set;
    logic all_set;
  } win_res_t;

endpackage

// File: hw/rtl/binary_morphology_filter.sv
// Binary morphology filter over a raster-order mask stream.
// Input stream: s_tdata carries the signed Q8.8 pixel level, s_tuser[0] marks a
// drain item that carries no pixel. Each pixel is foreground at level 128 or more.
// Output stream: m_tdata[0] is the filtered mask bit, m_tlast marks the last
// pixel of the frame. Result k of a frame comes out with input item k+D, where
// D = passes*(r*W+r); drain items after the frame flush the remaining results.
// The configuration channel writes mode, radius, width and height; any write to
// these four registers restarts the frame, and input is held off while it settles.
// Throughput: one item at a time, paced by the window scan, which reads one tap
// per cycle from the single read port of the selected line store. The output
// register loads in the finish state, after the last window tap has passed the
// issue, read and done registers and the wait state.
// A finished result waits in the output register; if the receiver stalls while
// a second result is ready, the block holds that item until the register frees.
// Reset restores the default registers and starts a new frame; the line
// stores are not cleared, since every read hits an entry written in the frame.
module binary_morphology_filter
  import bmf_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_RADIUS = 7
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // pixel_level
  input  logic [0:0]  s_tuser,   // operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // mask_bit, then zero fill
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [10:0] cfg_data
);

  localparam int XW    = $clog2(MAX_WIDTH + 1);
  localparam int YW    = $clog2(MAX_HEIGHT + 1);
  localparam int RW    = (MAX_RADIUS < 1) ? 1 : $clog2(MAX_RADIUS + 1);
  localparam int NW    = XW + YW;
  localparam int DW    = RW + XW + 1;
  localparam int WME   = (MAX_WIDTH > 2047) ? 2047 : MAX_WIDTH;
  localparam int RME   = (MAX_RADIUS > 7) ? 7 : MAX_RADIUS;
  localparam int D1MAX = RME * WME + RME;
  localparam int AW    = $clog2(2 * D1MAX + 2);

  state_t state;
  state_t state_next;

  logic              cfg_restart;
  logic              cfg_busy;
  mode_t             eff_mode;
  logic [RW-1:0]     eff_radius;
  logic [XW-1:0]     eff_width;
  logic [YW-1:0]     eff_height;
  logic [NW-1:0]     pix_total;
  logic [DW-1:0]     delay1;

  logic [CNT_W-1:0]  item_count;
  logic              p1;
  logic              p2;
  logic              emit;
  logic              out_bit;
  logic              out_last;
  logic [XW-1:0]     x1;
  logic [YW-1:0]     y1;
  logic [NW-1:0]     m1cnt;
  logic [XW-1:0]     x2;
  logic [YW-1:0]     y2;
  logic [NW-1:0]     m2cnt;

  logic              two;
  logic              accept;
  logic              in_frame;
  logic              is_drain;
  logic              fg;
  logic              out_free;
  logic              pass1_bit;
  logic              pass2_bit;
  logic              stage_bit;
  logic [31:0]       c32;
  logic [31:0]       n32;
  logic [31:0]       d32;
  logic [31:0]       m1_32;
  logic [NW-1:0]     last_k;

  win_req_t          win_req;
  win_res_t          win_res;
  logic              wr1_en;
  logic              wr2_en;
  logic [XW-1:0]     win_x;
  logic [YW-1:0]     win_y;

  bmf_cfg #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_RADIUS(MAX_RADIUS)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .restart   (cfg_restart),
    .busy      (cfg_busy),
    .eff_mode  (eff_mode),
    .eff_radius(eff_radius),
    .eff_width (eff_width),
    .eff_height(eff_height),
    .pix_total (pix_total),
    .delay1    (delay1)
  );

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE) && !cfg_busy;
  assign accept    = s_tvalid && s_tready;
  assign is_drain  = s_tuser[0];
  assign fg        = ($signed(s_tdata) >= FG_LEVEL);
  assign two       = (eff_mode == MODE_OPEN) || (eff_mode == MODE_CLOSE);
  assign out_free  = !m_tvalid || m_tready;
  assign last_k    = pix_total - NW'(1);

  assign c32      = 32'(item_count);
  assign n32      = 32'(pix_total);
  assign d32      = 32'(delay1);
  assign m1_32    = 32'(m1cnt);
  assign in_frame = (c32 < n32);

  assign wr1_en = accept && in_frame && !is_drain;

  always_comb begin
    case (eff_mode)
      MODE_DILATE:   pass1_bit = win_res.any_set;
      MODE_GRADIENT: pass1_bit = win_res.any_set & ~win_res.all_set;
      default:       pass1_bit = win_res.all_set;
    endcase
    stage_bit = (eff_mode == MODE_CLOSE) ? win_res.any_set : win_res.all_set;
    pass2_bit = (eff_mode == MODE_OPEN) ? win_res.any_set : win_res.all_set;
  end

  always_comb begin
    state_next     = state;
    win_req.start  = 1'b0;
    win_req.second = 1'b0;
    wr2_en         = 1'b0;
    win_x          = x1;
    win_y          = y1;
    unique case (state)
      ST_IDLE: begin
        if (accept && !(in_frame && is_drain)) begin
          if (c32 >= d32 && (c32 - d32) < n32) begin
            state_next = ST_PASS1;
          end else if (two && c32 >= (d32 << 1) && (c32 - (d32 << 1)) < n32) begin
            state_next = ST_PASS2;
          end else begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_PASS1: begin
        win_req.start = 1'b1;
        state_next    = ST_WAIT1;
      end
      ST_WAIT1: begin
        if (win_res.done) begin
          wr2_en     = two;
          state_next = p2 ? ST_PASS2 : ST_FINISH;
        end
      end
      ST_PASS2: begin
        win_req.start  = 1'b1;
        win_req.second = 1'b1;
        win_x          = x2;
        win_y          = y2;
        state_next     = ST_WAIT2;
      end
      ST_WAIT2: begin
        win_x = x2;
        win_y = y2;
        if (win_res.done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!emit || out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  bmf_window #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_RADIUS(MAX_RADIUS)
  ) u_window (
    .clk     (clk),
    .rst     (rst),
    .req     (win_req),
    .cx      (win_x),
    .cy      (win_y),
    .width   (eff_width),
    .height  (eff_height),
    .radius  (eff_radius),
    .wr1_en  (wr1_en),
    .wr1_addr(c32[AW-1:0]),
    .wr1_bit (fg),
    .wr2_en  (wr2_en),
    .wr2_addr(m1_32[AW-1:0]),
    .wr2_bit (stage_bit),
    .res     (win_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_count <= '0;
      p1         <= 1'b0;
      p2         <= 1'b0;
      emit       <= 1'b0;
      x1         <= '0;
      y1         <= '0;
      m1cnt      <= '0;
      x2         <= '0;
      y2         <= '0;
      m2cnt      <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      // A new result loaded in the finish state keeps the valid flag set.
      if (m_tvalid && m_tready && !(state == ST_FINISH && emit && !cfg_restart)) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_restart) begin
        item_count <= '0;
        x1         <= '0;
        y1         <= '0;
        m1cnt      <= '0;
        x2         <= '0;
        y2         <= '0;
        m2cnt      <= '0;
      end else begin
        case (state)
          ST_IDLE: begin
            if (accept) begin
              emit <= 1'b0;
              p1   <= (c32 >= d32) && ((c32 - d32) < n32);
              p2   <= two && (c32 >= (d32 << 1)) && ((c32 - (d32 << 1)) < n32);
            end
          end
          ST_WAIT1: begin
            if (win_res.done) begin
              if (!two) begin
                emit     <= 1'b1;
                out_bit  <= pass1_bit;
                out_last <= (m1cnt == last_k);
              end
              m1cnt <= m1cnt + NW'(1);
              if (x1 == eff_width - XW'(1)) begin
                x1 <= '0;
                y1 <= y1 + YW'(1);
              end else begin
                x1 <= x1 + XW'(1);
              end
            end
          end
          ST_WAIT2: begin
            if (win_res.done) begin
              emit     <= 1'b1;
              out_bit  <= pass2_bit;
              out_last <= (m2cnt == last_k);
              m2cnt    <= m2cnt + NW'(1);
              if (x2 == eff_width - XW'(1)) begin
                x2 <= '0;
                y2 <= y2 + YW'(1);
              end else begin
                x2 <= x2 + XW'(1);
              end
            end
          end
          ST_FINISH: begin
            if (!emit) begin
              item_count <= item_count + CNT_W'(1);
            end else if (out_free) begin
              m_tvalid   <= 1'b1;
              m_tdata    <= {7'd0, out_bit};
              m_tlast    <= out_last;
              // The last result of the frame starts the next one.
              if (out_last) begin
                item_count <= '0;
                x1         <= '0;
                y1         <= '0;
                m1cnt      <= '0;
                x2         <= '0;
                y2         <= '0;
                m2cnt      <= '0;
              end else begin
                item_count <= item_count + CNT_W'(1);
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    cfg_restart |=> (item_count == '0))
    else $error("frame restart did not clear the item counter");

  a_frame_end_wraps: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && emit && out_last && out_free && !cfg_restart)
      |=> (item_count == '0 && m1cnt == '0 && m2cnt == '0))
    else $error("frame end did not reset the pixel counters");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    win_res.done |-> (state == ST_WAIT1 || state == ST_WAIT2))
    else $error("window result arrived outside a wait state");

  a_p1_before_pass2: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PASS1) |-> p1)
    else $error("first pass started without a first-pass pixel");

endmodule

// File: hw/rtl/bmf_cfg.sv
module bmf_cfg
  import bmf_pkg::*;
#(
  parameter int  MAX_WIDTH  = 1024,
  parameter int  MAX_HEIGHT = 1024,
  parameter int  MAX_RADIUS = 7,
  localparam int XW = $clog2(MAX_WIDTH + 1),
  localparam int YW = $clog2(MAX_HEIGHT + 1),
  localparam int RW = (MAX_RADIUS < 1) ? 1 : $clog2(MAX_RADIUS + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [7:0]            cfg_index,
  input  logic [10:0]           cfg_data,
  output logic                  restart,
  output logic                  busy,
  output mode_t                 eff_mode,
  output logic [RW-1:0]         eff_radius,
  output logic [XW-1:0]         eff_width,
  output logic [YW-1:0]         eff_height,
  output logic [XW+YW-1:0]      pix_total,
  output logic [RW+XW:0]        delay1
);

  localparam int NW = XW + YW;
  localparam int DW = RW + XW + 1;

  logic [2:0]  mode_raw;
  logic [2:0]  radius_raw;
  logic [10:0] width_raw;
  logic [10:0] height_raw;
  logic [1:0]  settle;

  logic [31:0] w32;
  logic [31:0] h32;
  logic [31:0] r32;

  assign restart = cfg_we && (cfg_index <= REG_HEIGHT);
  assign busy    = (settle != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_raw   <= 3'd0;
      radius_raw <= 3'd1;
      width_raw  <= 11'd1024;
      height_raw <= 11'd1024;
      settle     <= 2'd2;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MODE:   mode_raw   <= cfg_data[2:0];
          REG_RADIUS: radius_raw <= cfg_data[2:0];
          REG_WIDTH:  width_raw  <= cfg_data;
          REG_HEIGHT: height_raw <= cfg_data;
          default: ;
        endcase
      end
      // Effective values register first, then the products.
      if (restart) begin
        settle <= 2'd2;
      end else if (settle != 2'd0) begin
        settle <= settle - 2'd1;
      end
    end
  end

  always_comb begin
    w32 = {21'd0, width_raw};
    if (w32 == 32'd0) begin
      w32 = 32'd1;
    end else if (w32 > 32'(MAX_WIDTH)) begin
      w32 = 32'(MAX_WIDTH);
    end
    h32 = {21'd0, height_raw};
    if (h32 == 32'd0) begin
      h32 = 32'd1;
    end else if (h32 > 32'(MAX_HEIGHT)) begin
      h32 = 32'(MAX_HEIGHT);
    end
    r32 = {29'd0, radius_raw};
    if (r32 > 32'(MAX_RADIUS)) begin
      r32 = 32'(MAX_RADIUS);
    end
  end

  always_ff @(posedge clk) begin
    eff_width  <= w32[XW-1:0];
    eff_height <= h32[YW-1:0];
    eff_radius <= r32[RW-1:0];
    eff_mode   <= (mode_raw > 3'(MODE_GRADIENT)) ? MODE_ERODE : mode_t'(mode_raw);
    pix_total  <= NW'(eff_width) * NW'(eff_height);
    delay1     <= DW'(eff_radius) * DW'(eff_width) + DW'(eff_radius);
  end

endmodule

// File: hw/rtl/bmf_window.sv
module bmf_window
  import bmf_pkg::*;
#(
  parameter int  MAX_WIDTH  = 1024,
  parameter int  MAX_HEIGHT = 1024,
  parameter int  MAX_RADIUS = 7,
  localparam int XW    = $clog2(MAX_WIDTH + 1),
  localparam int YW    = $clog2(MAX_HEIGHT + 1),
  localparam int RW    = (MAX_RADIUS < 1) ? 1 : $clog2(MAX_RADIUS + 1),
  localparam int WME   = (MAX_WIDTH > 2047) ? 2047 : MAX_WIDTH,
  localparam int RME   = (MAX_RADIUS > 7) ? 7 : MAX_RADIUS,
  localparam int D1MAX = RME * WME + RME,
  localparam int AW    = $clog2(2 * D1MAX + 2)
) (
  input  logic            clk,
  input  logic            rst,
  input  win_req_t        req,
  input  logic [XW-1:0]   cx,
  input  logic [YW-1:0]   cy,
  input  logic [XW-1:0]   width,
  input  logic [YW-1:0]   height,
  input  logic [RW-1:0]   radius,
  input  logic            wr1_en,
  input  logic [AW-1:0]   wr1_addr,
  input  logic            wr1_bit,
  input  logic            wr2_en,
  input  logic [AW-1:0]   wr2_addr,
  input  logic            wr2_bit,
  output win_res_t        res
);

  localparam int TW    = RW + 1;
  localparam int DEPTH = 1 << AW;
  localparam int FW    = (XW + YW > AW) ? XW + YW : AW;
  localparam int SYW   = ((YW > TW) ? YW : TW) + 2;
  localparam int SXW   = ((XW > TW) ? XW : TW) + 2;

  logic mem1 [DEPTH];
  logic mem2 [DEPTH];

  logic          scanning;
  logic          sel;
  logic [TW-1:0] tx;
  logic [TW-1:0] ty;
  logic [TW-1:0] span;

  logic [SYW-1:0] sy;
  logic [SXW-1:0] sx;
  logic [YW-1:0]  ny;
  logic [XW-1:0]  nx;
  logic [FW-1:0]  lin;

  logic [AW-1:0] addr_q;
  logic          issue_v;
  logic          issue_last;
  logic          rd1;
  logic          rd2;
  logic          rd_v;
  logic          rd_last;
  logic          rd_bit;
  logic          acc_and;
  logic          acc_or;
  logic          done;

  assign span = {radius, 1'b0};

  // Tap coordinates clamped to the frame, which replicates the borders.
  always_comb begin
    sy = SYW'(cy) + SYW'(ty) - SYW'(radius);
    sx = SXW'(cx) + SXW'(tx) - SXW'(radius);
    if (sy[SYW-1]) begin
      ny = '0;
    end else if (sy >= SYW'(height)) begin
      ny = height - YW'(1);
    end else begin
      ny = sy[YW-1:0];
    end
    if (sx[SXW-1]) begin
      nx = '0;
    end else if (sx >= SXW'(width)) begin
      nx = width - XW'(1);
    end else begin
      nx = sx[XW-1:0];
    end
    lin = FW'(ny) * FW'(width) + FW'(nx);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scanning   <= 1'b0;
      issue_v    <= 1'b0;
      issue_last <= 1'b0;
      rd_v       <= 1'b0;
      rd_last    <= 1'b0;
      done       <= 1'b0;
      tx         <= '0;
      ty         <= '0;
      sel        <= 1'b0;
    end else begin
      issue_v    <= scanning;
      issue_last <= scanning && (tx == span) && (ty == span);
      rd_v       <= issue_v;
      rd_last    <= issue_last;
      done       <= rd_v && rd_last;
      if (req.start) begin
        scanning <= 1'b1;
        tx       <= '0;
        ty       <= '0;
        sel      <= req.second;
      end else if (scanning) begin
        if (tx == span) begin
          tx <= '0;
          if (ty == span) begin
            scanning <= 1'b0;
          end else begin
            ty <= ty + TW'(1);
          end
        end else begin
          tx <= tx + TW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    addr_q <= lin[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (wr1_en) begin
      mem1[wr1_addr] <= wr1_bit;
    end
    rd1 <= mem1[addr_q];
  end

  always_ff @(posedge clk) begin
    if (wr2_en) begin
      mem2[wr2_addr] <= wr2_bit;
    end
    rd2 <= mem2[addr_q];
  end

  assign rd_bit = sel ? rd2 : rd1;

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc_and <= 1'b1;
      acc_or  <= 1'b0;
    end else if (rd_v) begin
      acc_and <= acc_and & rd_bit;
      acc_or  <= acc_or | rd_bit;
    end
  end

  assign res.done    = done;
  assign res.any_set = acc_or;
  assign res.all_set = acc_and;

endmodule
